// ===== hdl/cuc_pkg.sv =====
// ----------------------------------------------------------------------------
// cuc_pkg
// Shared types, constants and calendar helpers for the CUC / calendar
// time converter.
// ----------------------------------------------------------------------------
package cuc_pkg;

  // Offset reset value and time constants in seconds
  localparam logic [31:0] TAI_RESET      = 32'd378691200;
  localparam logic [31:0] SECS_DAY       = 32'd86400;
  localparam logic [31:0] SECS_HOUR      = 32'd3600;
  localparam logic [31:0] SECS_MIN       = 32'd60;
  localparam logic [31:0] SECS_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;

  // Year offsets counted from 1970
  localparam logic [7:0] YEAR_OFF_2000 = 8'd30;
  localparam logic [7:0] YEAR_OFF_2100 = 8'd130;

  localparam logic [3:0] MONTHS = 4'd12;

  // Reciprocals for constant division (quotient = x * R >> k)
  localparam logic [14:0] DAY_RECIP  = 15'd24856;  // (x>>7)/675,  k = 24
  localparam logic [12:0] HOUR_RECIP = 13'd4661;   // (x>>4)/225,  k = 20
  localparam logic [10:0] MIN_RECIP  = 11'd1093;   // (x>>2)/15,   k = 14
  localparam logic [15:0] FINE_RECIP = 16'd33555;  // ms*256/1000, k = 17

  // Datapath commands
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_YEAR_ADD,
    OP_MON_ADD,
    OP_DAY_ADD,
    OP_TIME_ADD,
    OP_YEAR_SUB,
    OP_MON_SUB,
    OP_DAY_DIV,
    OP_DAY_REM,
    OP_HOUR_DIV,
    OP_HOUR_REM,
    OP_MIN_DIV,
    OP_MIN_REM,
    OP_EMIT
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL_YEAR,
    ST_CAL_MON,
    ST_CAL_DAY,
    ST_CAL_TIME,
    ST_CUC_YEAR,
    ST_CUC_MON,
    ST_DAY_DIV,
    ST_DAY_REM,
    ST_HOUR_DIV,
    ST_HOUR_REM,
    ST_MIN_DIV,
    ST_MIN_REM,
    ST_EMIT
  } state_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic req;        // 1 = CUC to calendar
    logic year_done;  // year loop finished
    logic mon_done;   // month loop finished
    logic pre2000;    // decoded instant lies before 2000
  } dp_status_t;

  // Leap year test for year 1970 + yoff, valid up to 2199
  function automatic logic is_leap_off(logic [7:0] yoff);
    logic [7:0] y2;
    y2 = yoff + 8'd2;
    return (y2[1:0] == 2'b00) && (yoff != YEAR_OFF_2100);
  endfunction

  function automatic logic [31:0] year_secs(logic [7:0] yoff);
    return is_leap_off(yoff) ? SECS_LEAP_YEAR : SECS_YEAR;
  endfunction

  // Length of month m (0 = January) in seconds
  function automatic logic [31:0] month_secs(logic [3:0] m, logic leap);
    logic [31:0] len;
    unique case (m)
      4'd1:                   len = leap ? 32'd2505600 : 32'd2419200;
      4'd3, 4'd5, 4'd8, 4'd10: len = 32'd2592000;
      default:                len = 32'd2678400;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/cuc_calendar_time_converter.sv =====
// ----------------------------------------------------------------------------
// cuc_calendar_time_converter
// Converts between calendar time counted from 2000 and CUC coarse/fine time.
// ----------------------------------------------------------------------------
// One request is taken at a clock edge with start high and busy low; busy
// stays high until the result word appears on the out_ ports for exactly
// one cycle with out_valid high, and the receiver cannot stall it. A
// calendar to CUC request walks one year per cycle from 1970 up to the
// requested year, then one month per cycle. A CUC to calendar request
// walks one year per cycle from 1970 up to the decoded year (at most 2106),
// then, if that is 2000 or later, one month per cycle, then a divide and a
// remainder step each for day, hour and minute. The year loop through the
// single seconds accumulator sets the latency. tai_offset is to be written
// through cfg_wr_en and cfg_wr_data only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module cuc_calendar_time_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_req_type,
  input  logic [6:0]  in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [4:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  input  logic [9:0]  in_millisecond_in,
  input  logic [31:0] in_coarse_in,
  output logic        out_valid,
  output logic        out_status,
  output logic [31:0] out_coarse_out,
  output logic [7:0]  out_fine_out,
  output logic [6:0]  out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out
);
  import cuc_pkg::*;

  op_t        op;
  dp_status_t stat;

  // Sequencer
  cuc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  // Datapath
  cuc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_year_in        (in_year_in),
    .in_month_in       (in_month_in),
    .in_day_in         (in_day_in),
    .in_hour_in        (in_hour_in),
    .in_minute_in      (in_minute_in),
    .in_second_in      (in_second_in),
    .in_millisecond_in (in_millisecond_in),
    .in_coarse_in      (in_coarse_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_coarse_out    (out_coarse_out),
    .out_fine_out      (out_fine_out),
    .out_year_out      (out_year_out),
    .out_month_out     (out_month_out),
    .out_day_out       (out_day_out),
    .out_hour_out      (out_hour_out),
    .out_minute_out    (out_minute_out),
    .out_second_out    (out_second_out)
  );

endmodule

// ===== hdl/cuc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cuc_ctrl
// Sequencer for the converter: walks the year and month loops and the
// time-of-day split, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module cuc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cuc_pkg::dp_status_t stat,
  output cuc_pkg::op_t        op,
  output logic                busy
);
  import cuc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the sequence and pick the command
  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op        = OP_LOAD;
          state_nxt = stat.req ? ST_CUC_YEAR : ST_CAL_YEAR;
        end
      end
      ST_CAL_YEAR: begin
        if (stat.year_done) begin
          state_nxt = ST_CAL_MON;
        end else begin
          op = OP_YEAR_ADD;
        end
      end
      ST_CAL_MON: begin
        if (stat.mon_done) begin
          state_nxt = ST_CAL_DAY;
        end else begin
          op = OP_MON_ADD;
        end
      end
      ST_CAL_DAY: begin
        op        = OP_DAY_ADD;
        state_nxt = ST_CAL_TIME;
      end
      ST_CAL_TIME: begin
        op        = OP_TIME_ADD;
        state_nxt = ST_EMIT;
      end
      ST_CUC_YEAR: begin
        if (stat.year_done) begin
          state_nxt = stat.pre2000 ? ST_EMIT : ST_CUC_MON;
        end else begin
          op = OP_YEAR_SUB;
        end
      end
      ST_CUC_MON: begin
        if (stat.mon_done) begin
          state_nxt = ST_DAY_DIV;
        end else begin
          op = OP_MON_SUB;
        end
      end
      ST_DAY_DIV: begin
        op        = OP_DAY_DIV;
        state_nxt = ST_DAY_REM;
      end
      ST_DAY_REM: begin
        op        = OP_DAY_REM;
        state_nxt = ST_HOUR_DIV;
      end
      ST_HOUR_DIV: begin
        op        = OP_HOUR_DIV;
        state_nxt = ST_HOUR_REM;
      end
      ST_HOUR_REM: begin
        op        = OP_HOUR_REM;
        state_nxt = ST_MIN_DIV;
      end
      ST_MIN_DIV: begin
        op        = OP_MIN_DIV;
        state_nxt = ST_MIN_REM;
      end
      ST_MIN_REM: begin
        op        = OP_MIN_REM;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        op        = OP_EMIT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cuc_dp.sv =====
// ----------------------------------------------------------------------------
// cuc_dp
// Datapath: a 32-bit seconds accumulator with year and month counters,
// reciprocal dividers for day, hour and minute, the offset register and
// the result registers.
// ----------------------------------------------------------------------------
module cuc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cuc_pkg::op_t        op,
  output cuc_pkg::dp_status_t stat,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                in_req_type,
  input  logic [6:0]          in_year_in,
  input  logic [3:0]          in_month_in,
  input  logic [4:0]          in_day_in,
  input  logic [4:0]          in_hour_in,
  input  logic [5:0]          in_minute_in,
  input  logic [5:0]          in_second_in,
  input  logic [9:0]          in_millisecond_in,
  input  logic [31:0]         in_coarse_in,
  output logic                out_valid,
  output logic                out_status,
  output logic [31:0]         out_coarse_out,
  output logic [7:0]          out_fine_out,
  output logic [6:0]          out_year_out,
  output logic [3:0]          out_month_out,
  output logic [4:0]          out_day_out,
  output logic [4:0]          out_hour_out,
  output logic [5:0]          out_minute_out,
  output logic [5:0]          out_second_out
);
  import cuc_pkg::*;

  // Offset register
  logic [31:0] tai_r;

  // Working registers
  logic        req_r,    req_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [7:0]  yoff_r,   yoff_nxt;
  logic [7:0]  tgt_r,    tgt_nxt;
  logic [3:0]  mon_r,    mon_nxt;
  logic [3:0]  pm_r,     pm_nxt;
  logic [4:0]  day_r,    day_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [8:0]  fine_q_r, fine_q_nxt;
  logic [4:0]  dq_r,     dq_nxt;
  logic [4:0]  hq_r,     hq_nxt;
  logic [5:0]  mq_r,     mq_nxt;

  // Result registers
  logic        valid_r;
  logic        status_r;
  logic [31:0] coarse_r;
  logic [7:0]  fine_r;
  logic [6:0]  year_o_r;
  logic [3:0]  month_o_r;
  logic [4:0]  day_o_r;
  logic [4:0]  hour_o_r;
  logic [5:0]  minute_o_r;
  logic [5:0]  second_o_r;

  logic        leap;
  logic [31:0] cur_year_secs;
  logic [31:0] cur_mon_secs;
  logic        pre2000;
  logic [29:0] day_prod;
  logic [25:0] hour_prod;
  logic [20:0] min_prod;
  logic [25:0] fine_prod;

  // Loop lengths for the current year and month
  assign leap          = is_leap_off(yoff_r);
  assign cur_year_secs = year_secs(yoff_r);
  assign cur_mon_secs  = month_secs(mon_r, leap);
  assign pre2000       = (yoff_r < YEAR_OFF_2000);

  // Reciprocal products
  assign day_prod  = 30'(acc_r[21:7]) * 30'(DAY_RECIP);
  assign hour_prod = 26'(acc_r[16:4]) * 26'(HOUR_RECIP);
  assign min_prod  = 21'(acc_r[11:2]) * 21'(MIN_RECIP);
  assign fine_prod = 26'(in_millisecond_in) * 26'(FINE_RECIP);

  // Report loop status to the controller
  always_comb begin
    stat.req       = in_req_type;
    stat.pre2000   = pre2000;
    if (req_r) begin
      stat.year_done = (acc_r < cur_year_secs);
      stat.mon_done  = (mon_r == MONTHS) || (acc_r < cur_mon_secs);
    end else begin
      stat.year_done = (yoff_r == tgt_r);
      stat.mon_done  = (mon_r == pm_r);
    end
  end

  // Execute the command
  always_comb begin
    req_nxt    = req_r;
    acc_nxt    = acc_r;
    yoff_nxt   = yoff_r;
    tgt_nxt    = tgt_r;
    mon_nxt    = mon_r;
    pm_nxt     = pm_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    fine_q_nxt = fine_q_r;
    dq_nxt     = dq_r;
    hq_nxt     = hq_r;
    mq_nxt     = mq_r;
    unique case (op)
      OP_LOAD: begin
        req_nxt    = in_req_type;
        acc_nxt    = in_req_type ? (in_coarse_in - tai_r) : 32'd0;
        yoff_nxt   = 8'd0;
        tgt_nxt    = 8'(in_year_in) + YEAR_OFF_2000;
        mon_nxt    = 4'd0;
        day_nxt    = in_day_in;
        hour_nxt   = in_hour_in;
        minute_nxt = in_minute_in;
        second_nxt = in_second_in;
        fine_q_nxt = fine_prod[25:17];
        // month zero counts no months, months past December count all twelve
        if (in_month_in == 4'd0) begin
          pm_nxt = 4'd0;
        end else if (in_month_in > (MONTHS + 4'd1)) begin
          pm_nxt = MONTHS;
        end else begin
          pm_nxt = in_month_in - 4'd1;
        end
      end
      OP_YEAR_ADD: begin
        acc_nxt  = acc_r + cur_year_secs;
        yoff_nxt = yoff_r + 8'd1;
      end
      OP_MON_ADD: begin
        acc_nxt = acc_r + cur_mon_secs;
        mon_nxt = mon_r + 4'd1;
      end
      OP_DAY_ADD: begin
        // day zero wraps back one day
        acc_nxt = acc_r + 32'(day_r) * SECS_DAY - SECS_DAY;
      end
      OP_TIME_ADD: begin
        acc_nxt = acc_r + 32'(hour_r) * SECS_HOUR + 32'(minute_r) * SECS_MIN
                  + 32'(second_r) + tai_r;
      end
      OP_YEAR_SUB: begin
        acc_nxt  = acc_r - cur_year_secs;
        yoff_nxt = yoff_r + 8'd1;
      end
      OP_MON_SUB: begin
        acc_nxt = acc_r - cur_mon_secs;
        mon_nxt = mon_r + 4'd1;
      end
      OP_DAY_DIV: begin
        dq_nxt = day_prod[28:24];
      end
      OP_DAY_REM: begin
        acc_nxt = acc_r - 32'(dq_r) * SECS_DAY;
      end
      OP_HOUR_DIV: begin
        hq_nxt = hour_prod[24:20];
      end
      OP_HOUR_REM: begin
        acc_nxt = acc_r - 32'(hq_r) * SECS_HOUR;
      end
      OP_MIN_DIV: begin
        mq_nxt = min_prod[19:14];
      end
      OP_MIN_REM: begin
        acc_nxt = acc_r - 32'(mq_r) * SECS_MIN;
      end
      default: begin
      end
    endcase
  end

  // Hold the offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tai_r <= TAI_RESET;
    end else if (cfg_wr_en) begin
      tai_r <= cfg_wr_data;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    acc_r    <= acc_nxt;
    yoff_r   <= yoff_nxt;
    tgt_r    <= tgt_nxt;
    mon_r    <= mon_nxt;
    pm_r     <= pm_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    fine_q_r <= fine_q_nxt;
    dq_r     <= dq_nxt;
    hq_r     <= hq_nxt;
    mq_r     <= mq_nxt;
  end

  // Strobe the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (op == OP_EMIT);
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      status_r   <= 1'b0;
      coarse_r   <= 32'd0;
      fine_r     <= 8'd0;
      year_o_r   <= 7'd0;
      month_o_r  <= 4'd0;
      day_o_r    <= 5'd0;
      hour_o_r   <= 5'd0;
      minute_o_r <= 6'd0;
      second_o_r <= 6'd0;
      if (!req_r) begin
        coarse_r <= acc_r;
        fine_r   <= fine_q_r[8] ? 8'hFF : fine_q_r[7:0];
      end else if (pre2000) begin
        status_r <= 1'b1;
      end else begin
        year_o_r   <= 7'(yoff_r - YEAR_OFF_2000);
        month_o_r  <= mon_r + 4'd1;
        day_o_r    <= dq_r + 5'd1;
        hour_o_r   <= hq_r;
        minute_o_r <= mq_r;
        second_o_r <= acc_r[5:0];
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_coarse_out = coarse_r;
  assign out_fine_out   = fine_r;
  assign out_year_out   = year_o_r;
  assign out_month_out  = month_o_r;
  assign out_day_out    = day_o_r;
  assign out_hour_out   = hour_o_r;
  assign out_minute_out = minute_o_r;
  assign out_second_out = second_o_r;

endmodule

// ===== hdl/cuc_checker.sv =====
// ----------------------------------------------------------------------------
// cuc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module cuc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_status,
  input logic [31:0] out_coarse_out,
  input logic [7:0]  out_fine_out,
  input logic [6:0]  out_year_out,
  input logic [3:0]  out_month_out
);

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result word only appears once the block has gone idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // Finishing a request always delivers its word
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result word");

  // Words are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // An error word carries no time
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_coarse_out == 32'd0) && (out_fine_out == 8'd0)
      && (out_year_out == 7'd0) && (out_month_out == 4'd0))
    else $error("error word carries nonzero fields");

endmodule

bind cuc_calendar_time_converter cuc_checker u_cuc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_coarse_out (out_coarse_out),
  .out_fine_out   (out_fine_out),
  .out_year_out   (out_year_out),
  .out_month_out  (out_month_out)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CUC / calendar time converter. Requests go in
// through the start/busy handshake. An in-bench scoreboard predicts each
// result word from its own model of both conversion directions and the
// current TAI offset, and compares every strobed result field by field.
// Directed corner cases run first. Random phases follow, each under a new
// offset that is written while the block is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned PHASE_ITEMS = 330;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // One request word and one result word, laid out in port order
  typedef struct packed {
    bit        req_type;
    bit [6:0]  year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [5:0]  second;
    bit [9:0]  msec;
    bit [31:0] coarse;
  } time_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] coarse;
    logic [7:0]  fine;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } time_res_t;

  // Predict conversions and hold the result words still to come
  class conversion_scoreboard;
    bit [31:0]   tai_offset;
    time_res_t   due[$];
    int unsigned errors;

    function new();
      tai_offset = cuc_pkg::TAI_RESET;
      errors = 0;
    endfunction

    static function bit is_leap(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Month index 0 is January
    static function int unsigned month_days(int unsigned idx, int unsigned yr);
      case (idx)
        1:             return is_leap(yr) ? 29 : 28;
        3, 5, 8, 10:   return 30;
        default:       return 31;
      endcase
    endfunction

    function time_res_t convert(time_req_t r);
      time_res_t   res;
      int unsigned yr;
      int unsigned days;
      int unsigned prior;
      int unsigned secs;
      int unsigned fine;
      int unsigned ts;
      int unsigned span;
      int unsigned m;
      res = '0;
      if (!r.req_type) begin
        // Count days from 1970, then months before this one, then the day
        yr = 2000 + r.year;
        days = 0;
        for (int unsigned y = 1970; y < yr; y++) days += is_leap(y) ? 366 : 365;
        prior = (r.month == 0) ? 0 : r.month - 1;
        if (prior > 12) prior = 12;
        for (int unsigned i = 0; i < prior; i++) days += month_days(i, yr);
        days = days + r.day - 32'd1;
        secs = days * 86400 + r.hour * 3600 + r.minute * 60 + r.second;
        fine = r.msec * 256 / 1000;
        res.coarse = secs + tai_offset;
        res.fine = (fine > 255) ? 8'd255 : fine[7:0];
      end else begin
        // Peel whole years, then whole months, then split the day
        ts = r.coarse - tai_offset;
        yr = 1970;
        forever begin
          span = (is_leap(yr) ? 366 : 365) * 86400;
          if (ts < span) break;
          ts -= span;
          yr++;
        end
        if (yr < 2000) begin
          res.status = 1'b1;
          return res;
        end
        m = 0;
        while (m < 12) begin
          span = month_days(m, yr) * 86400;
          if (ts < span) break;
          ts -= span;
          m++;
        end
        res.year = 7'(yr - 2000);
        res.month = 4'(m + 1);
        res.day = 5'(ts / 86400 + 1);
        ts %= 86400;
        res.hour = 5'(ts / 3600);
        ts %= 3600;
        res.minute = 6'(ts / 60);
        res.second = 6'(ts % 60);
      end
      return res;
    endfunction

    function void note_request(time_req_t r);
      due.push_back(convert(r));
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(time_res_t got);
      time_res_t want;
      if (due.size() == 0) begin
        $error("result word with none pending: status %0d coarse %0h",
               got.status, got.coarse);
        errors++;
        return;
      end
      want = due.pop_front();
      compare("status", want.status, got.status);
      compare("coarse_out", want.coarse, got.coarse);
      compare("fine_out", want.fine, got.fine);
      compare("year_out", want.year, got.year);
      compare("month_out", want.month, got.month);
      compare("day_out", want.day, got.day);
      compare("hour_out", want.hour, got.hour);
      compare("minute_out", want.minute, got.minute);
      compare("second_out", want.second, got.second);
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_req_type;
  logic [6:0]  in_year_in;
  logic [3:0]  in_month_in;
  logic [4:0]  in_day_in;
  logic [4:0]  in_hour_in;
  logic [5:0]  in_minute_in;
  logic [5:0]  in_second_in;
  logic [9:0]  in_millisecond_in;
  logic [31:0] in_coarse_in;
  logic        out_valid;
  logic        out_status;
  logic [31:0] out_coarse_out;
  logic [7:0]  out_fine_out;
  logic [6:0]  out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;

  conversion_scoreboard sb;
  bit gaps_on;

  cuc_calendar_time_converter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_year_in        (in_year_in),
    .in_month_in       (in_month_in),
    .in_day_in         (in_day_in),
    .in_hour_in        (in_hour_in),
    .in_minute_in      (in_minute_in),
    .in_second_in      (in_second_in),
    .in_millisecond_in (in_millisecond_in),
    .in_coarse_in      (in_coarse_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_coarse_out    (out_coarse_out),
    .out_fine_out      (out_fine_out),
    .out_year_out      (out_year_out),
    .out_month_out     (out_month_out),
    .out_day_out       (out_day_out),
    .out_hour_out      (out_hour_out),
    .out_minute_out    (out_minute_out),
    .out_second_out    (out_second_out)
  );

  always #5 clk = ~clk;

  // Check the result word first, then note a request taken at the same edge
  always @(posedge clk) begin
    time_res_t got;
    time_req_t req;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_status, out_coarse_out, out_fine_out, out_year_out, out_month_out,
               out_day_out, out_hour_out, out_minute_out, out_second_out};
        sb.check_result(got);
      end
      if (start && !busy) begin
        req = {in_req_type, in_year_in, in_month_in, in_day_in, in_hour_in,
               in_minute_in, in_second_in, in_millisecond_in, in_coarse_in};
        sb.note_request(req);
      end
    end
  end

  // Give up when neither side moves a word for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("tb failed");
    $finish;
  end

  // Fill every field with random bits
  function automatic time_req_t random_bits();
    time_req_t r;
    r.req_type = 1'($urandom);
    r.year = 7'($urandom);
    r.month = 4'($urandom);
    r.day = 5'($urandom);
    r.hour = 5'($urandom);
    r.minute = 6'($urandom);
    r.second = 6'($urandom);
    r.msec = 10'($urandom);
    r.coarse = $urandom;
    return r;
  endfunction

  function automatic time_req_t cal_req(int unsigned yr, int unsigned mo, int unsigned dy,
                                        int unsigned hr, int unsigned mi, int unsigned se,
                                        int unsigned ms);
    time_req_t r;
    r = random_bits();
    r.req_type = 1'b0;
    r.year = 7'(yr);
    r.month = 4'(mo);
    r.day = 5'(dy);
    r.hour = 5'(hr);
    r.minute = 6'(mi);
    r.second = 6'(se);
    r.msec = 10'(ms);
    return r;
  endfunction

  function automatic time_req_t cuc_req(bit [31:0] coarse);
    time_req_t r;
    r = random_bits();
    r.req_type = 1'b1;
    r.coarse = coarse;
    return r;
  endfunction

  // Decode request for a given Unix time under the current offset
  function automatic time_req_t cuc_unix(bit [31:0] unix);
    return cuc_req(unix + sb.tai_offset);
  endfunction

  // Decode request that should give back the calendar request c
  function automatic time_req_t cuc_of(time_req_t c);
    time_res_t enc;
    enc = sb.convert(c);
    return cuc_req(enc.coarse);
  endfunction

  // Well-formed date, biased toward month and year edges
  function automatic time_req_t valid_calendar(int unsigned max_year);
    time_req_t   r;
    int unsigned pick;
    r = cal_req($urandom_range(0, max_year), $urandom_range(1, 12), 1,
                $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                $urandom_range(0, 999));
    pick = $urandom_range(0, 9);
    if (pick == 2) r.month = 4'd12;
    r.day = 5'($urandom_range(1, conversion_scoreboard::month_days(r.month - 1,
                                                                   2000 + r.year)));
    if (pick == 0 || pick == 2) begin
      r.day = 5'(conversion_scoreboard::month_days(r.month - 1, 2000 + r.year));
      r.hour = 5'd23;
      r.minute = 6'd59;
      r.second = 6'd59;
    end else if (pick == 1) begin
      r.day = 5'd1;
      r.hour = 5'd0;
      r.minute = 6'd0;
      r.second = 6'd0;
    end
    return r;
  endfunction

  function automatic time_req_t next_random_request();
    time_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = valid_calendar(99);
    end else if (pick < 50) begin
      r = random_bits();
      r.req_type = 1'b0;
    end else if (pick < 78) begin
      r = cuc_of(valid_calendar(106));
    end else if (pick < 88) begin
      // Straddle the start of 2000
      r = cuc_unix(32'd946684800 + $urandom_range(0, 400000) - 32'd200000);
    end else begin
      r = random_bits();
      r.req_type = 1'b1;
    end
    return r;
  endfunction

  // Present one request word and hold it until the block takes it
  task automatic send_request(time_req_t r);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 180) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type <= r.req_type;
    in_year_in <= r.year;
    in_month_in <= r.month;
    in_day_in <= r.day;
    in_hour_in <= r.hour;
    in_minute_in <= r.minute;
    in_second_in <= r.second;
    in_millisecond_in <= r.msec;
    in_coarse_in <= r.coarse;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drain, load a new offset while idle, then run a random burst
  task automatic run_phase(bit [31:0] offset, bit with_gaps);
    while (sb.pending() != 0 || busy) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= offset;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.tai_offset = offset;
    gaps_on = with_gaps;
    repeat (PHASE_ITEMS) send_request(next_random_request());
    start <= 1'b0;
  endtask

  initial begin
    sb = new();
    gaps_on = 1'b1;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_req_type = 1'b0;
    in_year_in = '0;
    in_month_in = '0;
    in_day_in = '0;
    in_hour_in = '0;
    in_minute_in = '0;
    in_second_in = '0;
    in_millisecond_in = '0;
    in_coarse_in = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Calendar to CUC corners under the reset offset
    send_request(cal_req(0, 1, 1, 0, 0, 0, 0));
    send_request(cal_req(99, 12, 31, 23, 59, 59, 999));
    send_request(cal_req(127, 15, 31, 31, 63, 63, 1023));
    send_request(cal_req(0, 0, 0, 0, 0, 0, 0));
    send_request(cal_req(0, 2, 29, 12, 0, 0, 500));
    send_request(cal_req(0, 3, 1, 0, 0, 0, 1));
    send_request(cal_req(100, 2, 28, 23, 59, 59, 1000));
    send_request(cal_req(100, 3, 1, 0, 0, 0, 4));
    send_request(cal_req(0, 13, 1, 0, 0, 0, 0));
    send_request(cal_req(106, 2, 7, 6, 28, 15, 0));
    // CUC to calendar: first second of 2000 and the one before it
    send_request(cuc_unix(32'd946684800));
    send_request(cuc_unix(32'd946684799));
    send_request(cuc_unix(32'd0));
    send_request(cuc_unix(32'hFFFF_FFFF));
    send_request(cuc_req(32'd0));
    send_request(cuc_req(32'hFFFF_FFFF));
    // Leap day of 2000 and the last second of that year
    send_request(cuc_unix(32'd951782400));
    send_request(cuc_unix(32'd978307199));
    // 2100 is not a leap year
    send_request(cuc_of(cal_req(100, 2, 28, 23, 59, 59, 0)));
    send_request(cuc_of(cal_req(100, 3, 1, 0, 0, 0, 0)));
    send_request(cuc_of(cal_req(4, 2, 29, 23, 59, 59, 0)));
    start <= 1'b0;

    // Random phases; the second one runs with no gaps at all
    run_phase(32'h0, 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b0);
    run_phase($urandom, 1'b1);
    run_phase(cuc_pkg::TAI_RESET, 1'b1);
    run_phase($urandom_range(0, 1000), 1'b1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cuc_pkg.sv
hdl/cuc_ctrl.sv
hdl/cuc_dp.sv
hdl/cuc_calendar_time_converter.sv
hdl/cuc_checker.sv
tb/tb.sv
